FILE: sv/vfc_pkg.sv
// Shared types, constants and fixed-point helpers of the view frustum culling unit.
// No dependencies; every other file imports this package.
package vfc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;

    localparam int IN_W   = 32;
    localparam int EXT_W  = 31;
    localparam int KIND_W = 3;
    localparam int IDX_W  = 4;
    localparam int WIDE_W = 64;

    localparam int ACC_W  = WORD_BITS + 3;
    localparam int SQ_W   = 2 * WORD_BITS;
    localparam int SH_W   = SQ_W - FRAC_BITS + 1;
    localparam int DIV_W  = ((2 * FRAC_BITS > WORD_BITS) ? 2 * FRAC_BITS : WORD_BITS) + 1;
    localparam int SQRT_STEPS = WORD_BITS;
    localparam int ITER_W = $clog2(DIV_W);

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic signed [ACC_W-1:0]     t_acc;
    typedef logic [KIND_W-1:0]           t_kind;

    localparam t_word WMAX = t_word'({1'b0, {(WORD_BITS-1){1'b1}}});
    localparam t_word WMIN = t_word'({1'b1, {(WORD_BITS-1){1'b0}}});

    localparam t_kind KIND_LD_PROJ = 3'd0;
    localparam t_kind KIND_LD_MV   = 3'd1;
    localparam t_kind KIND_COMPUTE = 3'd2;
    localparam t_kind KIND_POINT   = 3'd3;
    localparam t_kind KIND_SPHERE  = 3'd4;
    localparam t_kind KIND_CUBE    = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_CLIP_MUL, S_CLIP_ACC, S_CLIP_WR, S_PL_SUM, S_PL_CHK,
        S_SQ_MUL, S_SQ_ACC, S_SQRT_INIT, S_SQRT, S_DIV_INIT, S_DIV, S_NORM,
        S_T_CORNER, S_T_MUL, S_T_ACC, S_T_CMP, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_MUL_CLIP, OP_ACC, OP_WR_CLIP, OP_PL_SUM, OP_CHK,
        OP_SQ_MUL, OP_SQ_ACC, OP_SQRT_INIT, OP_SQRT_STEP, OP_DIV_INIT, OP_DIV_STEP,
        OP_NORM, OP_CORNER, OP_T_MUL
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       capture;
        logic       first;
        logic [1:0] row;
        logic [1:0] col;
        logic [1:0] k;
        logic [1:0] term;
        logic [2:0] plane;
        logic [2:0] corner;
    } t_cmd;

    typedef struct packed {
        logic ok;
        logic zero_normal;
        logic degen;
    } t_stat;

    typedef struct packed {
        t_kind                  kind;
        logic [IDX_W-1:0]       element_index;
        logic signed [IN_W-1:0] element_value;
        logic signed [IN_W-1:0] pos_x;
        logic signed [IN_W-1:0] pos_y;
        logic signed [IN_W-1:0] pos_z;
        logic [EXT_W-1:0]       extent;
    } t_req;

    function automatic t_word sat_wide(logic signed [WIDE_W-1:0] v);
        t_word r;
        if (v > WIDE_W'(WMAX)) begin
            r = WMAX;
        end else if (v < WIDE_W'(WMIN)) begin
            r = WMIN;
        end else begin
            r = v[WORD_BITS-1:0];
        end
        return r;
    endfunction

    function automatic t_word sat_in(logic signed [IN_W-1:0] v);
        logic signed [WIDE_W-1:0] e;
        e = WIDE_W'(v);
        return sat_wide(e);
    endfunction

    function automatic t_word sat_ext(logic [EXT_W-1:0] v);
        logic signed [WIDE_W-1:0] e;
        e = {{(WIDE_W-EXT_W){1'b0}}, v};
        return sat_wide(e);
    endfunction

    function automatic t_word sat_acc(t_acc v);
        t_word r;
        if (v > t_acc'(WMAX)) begin
            r = WMAX;
        end else if (v < t_acc'(WMIN)) begin
            r = WMIN;
        end else begin
            r = v[WORD_BITS-1:0];
        end
        return r;
    endfunction

    function automatic t_word corner_coord(t_word c, t_word s, logic up);
        t_acc sum;
        sum = up ? t_acc'(c) + t_acc'(s) : t_acc'(c) - t_acc'(s);
        return sat_acc(sum);
    endfunction

    function automatic logic [WORD_BITS-1:0] mag_w(t_word a);
        return a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
    endfunction

    // Round half away from zero to FRAC_BITS, clamp to the word range.
    function automatic t_word mul_round(logic [SQ_W-1:0] raw, logic neg);
        logic [SQ_W:0]   rnd;
        logic [SH_W-1:0] sh;
        logic [SH_W-1:0] lim;
        t_word           mg;
        rnd = {1'b0, raw} + ((SQ_W+1)'(1) << (FRAC_BITS - 1));
        sh  = rnd[SQ_W:FRAC_BITS];
        lim = neg ? SH_W'(WMAX) + SH_W'(1) : SH_W'(WMAX);
        if (sh > lim) begin
            sh = lim;
        end
        mg = sh[WORD_BITS-1:0];
        return neg ? -mg : mg;
    endfunction

    // right, left, bottom, top, back, front
    function automatic logic [1:0] plane_col(logic [2:0] p);
        logic [1:0] c;
        case (p)
            3'd0, 3'd1: c = 2'd0;
            3'd2, 3'd3: c = 2'd1;
            default:    c = 2'd2;
        endcase
        return c;
    endfunction

    function automatic logic plane_sub(logic [2:0] p);
        return (p == 3'd0) || (p == 3'd3) || (p == 3'd4);
    endfunction

endpackage

FILE: sv/vfc_if.sv
// Request and response channel interfaces of the view frustum culling unit.
// Depends on vfc_pkg.
interface vfc_req_if import vfc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    t_kind                  kind;
    logic [IDX_W-1:0]       element_index;
    logic signed [IN_W-1:0] element_value;
    logic signed [IN_W-1:0] pos_x;
    logic signed [IN_W-1:0] pos_y;
    logic signed [IN_W-1:0] pos_z;
    logic [EXT_W-1:0]       extent;

    modport source (output valid, kind, element_index, element_value, pos_x, pos_y, pos_z,
                    extent, input ready);
    modport sink (input valid, kind, element_index, element_value, pos_x, pos_y, pos_z,
                  extent, output ready);
endinterface

interface vfc_rsp_if;
    logic valid;
    logic ready;
    logic inside_res;
    logic degenerate;

    modport source (output valid, inside_res, degenerate, input ready);
    modport sink (input valid, inside_res, degenerate, output ready);
endinterface

FILE: sv/vfc_dp.sv
// Datapath: matrix and plane stores, shared multiplier, accumulator, sqrt and divider.
// Depends on vfc_pkg; driven by vfc_ctrl commands.
module vfc_dp import vfc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  t_req  i_req,
    output t_stat o_stat
);
    t_word r_proj [16];
    t_word r_mv   [16];
    t_word r_clip [4][4];
    t_word r_plane[6][4];

    t_kind            r_kind;
    logic [IDX_W-1:0] r_idx;
    t_word            r_val, r_x, r_y, r_z, r_ext;
    t_word            r_cx, r_cy, r_cz;
    t_acc             r_prod, r_acc;
    logic [SQ_W-1:0]  r_sq, r_ssq, r_rem, r_root, r_bit;
    logic [DIV_W-1:0] r_num, r_drem;
    logic             r_degen;

    t_word               m_a, m_b, coord, recip, m_q;
    logic [SQ_W-1:0]     raw;
    logic [SQ_W-1:0]     sq_try;
    logic [WORD_BITS-1:0] len;
    logic [DIV_W-1:0]    d_try;
    t_acc                pl_s, thr;
    t_word               pl_sum;
    logic                zero_n;

    always_comb begin
        case (i_cmd.term)
            2'd0:    coord = r_cx;
            2'd1:    coord = r_cy;
            default: coord = r_cz;
        endcase
    end

    assign len   = (r_root[WORD_BITS-1:0] == '0) ? WORD_BITS'(1) : r_root[WORD_BITS-1:0];
    assign recip = (r_num > DIV_W'(WMAX)) ? WMAX : t_word'(r_num[WORD_BITS-1:0]);

    always_comb begin
        m_a = r_plane[i_cmd.plane][i_cmd.term];
        m_b = coord;
        case (i_cmd.op)
            OP_MUL_CLIP: begin
                m_a = r_mv[{i_cmd.row, i_cmd.k}];
                m_b = r_proj[{i_cmd.k, i_cmd.col}];
            end
            OP_NORM: begin
                m_a = r_plane[i_cmd.plane][i_cmd.row];
                m_b = recip;
            end
            OP_SQ_MUL: m_b = r_plane[i_cmd.plane][i_cmd.term];
            default: ;
        endcase
    end

    assign raw = SQ_W'(mag_w(m_a)) * SQ_W'(mag_w(m_b));
    assign m_q = mul_round(raw, m_a[WORD_BITS-1] ^ m_b[WORD_BITS-1]);

    assign pl_s = plane_sub(i_cmd.plane)
        ? t_acc'(r_clip[i_cmd.row][3]) - t_acc'(r_clip[i_cmd.row][plane_col(i_cmd.plane)])
        : t_acc'(r_clip[i_cmd.row][3]) + t_acc'(r_clip[i_cmd.row][plane_col(i_cmd.plane)]);
    assign pl_sum = sat_acc(pl_s);

    assign zero_n = (r_plane[i_cmd.plane][0] == '0) && (r_plane[i_cmd.plane][1] == '0)
                 && (r_plane[i_cmd.plane][2] == '0);

    assign sq_try = r_root + r_bit;
    assign d_try  = {r_drem[DIV_W-2:0], r_num[DIV_W-1]};
    assign thr    = (r_kind == KIND_SPHERE) ? -t_acc'(r_ext) : '0;

    assign o_stat.ok          = r_acc > thr;
    assign o_stat.zero_normal = zero_n;
    assign o_stat.degen       = r_degen;

    // stores with a defined reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_proj[i] <= '0;
                r_mv[i]   <= '0;
            end
            for (int p = 0; p < 6; p++) begin
                for (int j = 0; j < 4; j++) begin
                    r_plane[p][j] <= '0;
                end
            end
            r_degen <= 1'b0;
        end else begin
            if (i_cmd.op == OP_LOAD && r_kind == KIND_LD_PROJ) r_proj[r_idx] <= r_val;
            if (i_cmd.op == OP_LOAD && r_kind == KIND_LD_MV) r_mv[r_idx] <= r_val;
            if (i_cmd.op == OP_PL_SUM) r_plane[i_cmd.plane][i_cmd.row] <= pl_sum;
            if (i_cmd.op == OP_NORM) r_plane[i_cmd.plane][i_cmd.row] <= m_q;
            if (i_cmd.capture) begin
                r_degen <= 1'b0;
            end else if (i_cmd.op == OP_CHK && zero_n) begin
                r_degen <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_req.kind;
            r_idx  <= i_req.element_index;
            r_val  <= sat_in(i_req.element_value);
            r_x    <= sat_in(i_req.pos_x);
            r_y    <= sat_in(i_req.pos_y);
            r_z    <= sat_in(i_req.pos_z);
            r_ext  <= sat_ext(i_req.extent);
        end
        case (i_cmd.op)
            OP_MUL_CLIP: r_prod <= t_acc'(m_q);
            OP_T_MUL: r_prod <= (i_cmd.term == 2'd3) ? t_acc'(r_plane[i_cmd.plane][3])
                                                    : t_acc'(m_q);
            OP_ACC: r_acc <= (i_cmd.first ? t_acc'(0) : r_acc) + r_prod;
            OP_WR_CLIP: r_clip[i_cmd.row][i_cmd.col] <= sat_acc(r_acc);
            OP_SQ_MUL: r_sq <= raw;
            OP_SQ_ACC: r_ssq <= (i_cmd.first ? SQ_W'(0) : r_ssq) + r_sq;
            OP_SQRT_INIT: begin
                r_rem  <= r_ssq;
                r_root <= '0;
                r_bit  <= SQ_W'(1) << (SQ_W - 2);
            end
            OP_SQRT_STEP: begin
                if (r_rem >= sq_try) begin
                    r_rem  <= r_rem - sq_try;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_DIV_INIT: begin
                r_num  <= (DIV_W'(1) << (2 * FRAC_BITS)) + DIV_W'(len >> 1);
                r_drem <= '0;
            end
            OP_DIV_STEP: begin
                if (d_try >= DIV_W'(len)) begin
                    r_drem <= d_try - DIV_W'(len);
                    r_num  <= {r_num[DIV_W-2:0], 1'b1};
                end else begin
                    r_drem <= d_try;
                    r_num  <= {r_num[DIV_W-2:0], 1'b0};
                end
            end
            OP_CORNER: begin
                if (r_kind == KIND_CUBE) begin
                    r_cx <= corner_coord(r_x, r_ext, i_cmd.corner[0]);
                    r_cy <= corner_coord(r_y, r_ext, i_cmd.corner[1]);
                    r_cz <= corner_coord(r_z, r_ext, i_cmd.corner[2]);
                end else begin
                    r_cx <= r_x;
                    r_cy <= r_y;
                    r_cz <= r_z;
                end
            end
            default: ;
        endcase
    end
endmodule

FILE: sv/vfc_ctrl.sv
// Controller: sequencer state machine, loop counters and the response register.
// Depends on vfc_pkg; commands vfc_dp.
module vfc_ctrl import vfc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    input  t_kind i_kind,
    output logic  o_req_ready,
    output t_cmd  o_cmd,
    input  t_stat i_stat,
    output logic  o_rsp_valid,
    input  logic  i_rsp_ready,
    output logic  o_inside,
    output logic  o_degen
);
    t_state r_state, n_state;
    logic [1:0] r_row, n_row, r_col, n_col, r_k, n_k, r_term, n_term;
    logic [2:0] r_plane, n_plane, r_corner, n_corner;
    logic [ITER_W-1:0] r_n, n_n;
    t_kind r_kind, n_kind;
    logic r_inside, n_inside;
    logic r_out_valid, r_out_inside, r_out_degen;
    logic fire;

    assign o_req_ready = (r_state == S_IDLE);
    assign fire = (r_state == S_DONE) && (!r_out_valid || i_rsp_ready);

    always_comb begin
        n_state = r_state; n_row = r_row; n_col = r_col; n_k = r_k; n_term = r_term;
        n_plane = r_plane; n_corner = r_corner; n_n = r_n; n_kind = r_kind;
        n_inside = r_inside;
        case (r_state)
            S_IDLE: if (i_req_valid) begin
                n_kind = i_kind; n_row = '0; n_col = '0; n_k = '0; n_term = '0;
                n_plane = '0; n_corner = '0; n_n = '0; n_inside = 1'b0;
                case (i_kind)
                    KIND_LD_PROJ, KIND_LD_MV: n_state = S_LOAD;
                    KIND_COMPUTE: n_state = S_CLIP_MUL;
                    KIND_POINT, KIND_SPHERE, KIND_CUBE: n_state = S_T_CORNER;
                    default: n_state = S_DONE;
                endcase
            end
            S_LOAD: n_state = S_DONE;
            S_CLIP_MUL: n_state = S_CLIP_ACC;
            S_CLIP_ACC: begin
                if (r_k == 2'd3) begin
                    n_state = S_CLIP_WR;
                end else begin
                    n_k = r_k + 2'd1;
                    n_state = S_CLIP_MUL;
                end
            end
            S_CLIP_WR: begin
                n_k = '0;
                n_state = S_CLIP_MUL;
                if (r_col == 2'd3) begin
                    n_col = '0;
                    n_row = r_row + 2'd1;
                    if (r_row == 2'd3) begin
                        n_state = S_PL_SUM;
                        n_plane = '0;
                    end
                end else begin
                    n_col = r_col + 2'd1;
                end
            end
            S_PL_SUM: begin
                if (r_row == 2'd3) begin
                    n_state = S_PL_CHK;
                end else begin
                    n_row = r_row + 2'd1;
                end
            end
            S_PL_CHK: begin
                if (i_stat.zero_normal) begin
                    n_row = '0;
                    if (r_plane == 3'd5) begin
                        n_state = S_DONE;
                    end else begin
                        n_plane = r_plane + 3'd1;
                        n_state = S_PL_SUM;
                    end
                end else begin
                    n_term = '0;
                    n_state = S_SQ_MUL;
                end
            end
            S_SQ_MUL: n_state = S_SQ_ACC;
            S_SQ_ACC: begin
                if (r_term == 2'd2) begin
                    n_state = S_SQRT_INIT;
                end else begin
                    n_term = r_term + 2'd1;
                    n_state = S_SQ_MUL;
                end
            end
            S_SQRT_INIT: begin
                n_n = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                if (r_n == ITER_W'(SQRT_STEPS - 1)) begin
                    n_state = S_DIV_INIT;
                end else begin
                    n_n = r_n + ITER_W'(1);
                end
            end
            S_DIV_INIT: begin
                n_n = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_n == ITER_W'(DIV_W - 1)) begin
                    n_row = '0;
                    n_state = S_NORM;
                end else begin
                    n_n = r_n + ITER_W'(1);
                end
            end
            S_NORM: begin
                if (r_row == 2'd3) begin
                    n_row = '0;
                    if (r_plane == 3'd5) begin
                        n_state = S_DONE;
                    end else begin
                        n_plane = r_plane + 3'd1;
                        n_state = S_PL_SUM;
                    end
                end else begin
                    n_row = r_row + 2'd1;
                end
            end
            S_T_CORNER: begin
                n_term = '0;
                n_state = S_T_MUL;
            end
            S_T_MUL: n_state = S_T_ACC;
            S_T_ACC: begin
                if (r_term == 2'd3) begin
                    n_state = S_T_CMP;
                end else begin
                    n_term = r_term + 2'd1;
                    n_state = S_T_MUL;
                end
            end
            S_T_CMP: begin
                if (i_stat.ok) begin
                    n_corner = '0;
                    if (r_plane == 3'd5) begin
                        n_inside = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_plane = r_plane + 3'd1;
                        n_state = S_T_CORNER;
                    end
                end else if (r_kind == KIND_CUBE && r_corner != 3'd7) begin
                    n_corner = r_corner + 3'd1;
                    n_state = S_T_CORNER;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: if (fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.op      = OP_NONE;
        o_cmd.capture = (r_state == S_IDLE) && i_req_valid;
        o_cmd.row     = r_row;
        o_cmd.col     = r_col;
        o_cmd.k       = r_k;
        o_cmd.term    = r_term;
        o_cmd.plane   = r_plane;
        o_cmd.corner  = r_corner;
        case (r_state)
            S_LOAD:      o_cmd.op = OP_LOAD;
            S_CLIP_MUL:  o_cmd.op = OP_MUL_CLIP;
            S_CLIP_ACC: begin
                o_cmd.op    = OP_ACC;
                o_cmd.first = (r_k == 2'd0);
            end
            S_CLIP_WR:   o_cmd.op = OP_WR_CLIP;
            S_PL_SUM:    o_cmd.op = OP_PL_SUM;
            S_PL_CHK:    o_cmd.op = OP_CHK;
            S_SQ_MUL:    o_cmd.op = OP_SQ_MUL;
            S_SQ_ACC: begin
                o_cmd.op    = OP_SQ_ACC;
                o_cmd.first = (r_term == 2'd0);
            end
            S_SQRT_INIT: o_cmd.op = OP_SQRT_INIT;
            S_SQRT:      o_cmd.op = OP_SQRT_STEP;
            S_DIV_INIT:  o_cmd.op = OP_DIV_INIT;
            S_DIV:       o_cmd.op = OP_DIV_STEP;
            S_NORM:      o_cmd.op = OP_NORM;
            S_T_CORNER:  o_cmd.op = OP_CORNER;
            S_T_MUL:     o_cmd.op = OP_T_MUL;
            S_T_ACC: begin
                o_cmd.op    = OP_ACC;
                o_cmd.first = (r_term == 2'd0);
            end
            default:     o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row; r_col <= n_col; r_k <= n_k; r_term <= n_term;
        r_plane <= n_plane; r_corner <= n_corner; r_n <= n_n;
        r_kind <= n_kind; r_inside <= n_inside;
        if (fire) begin
            r_out_inside <= r_inside;
            r_out_degen  <= i_stat.degen;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_inside    = r_out_inside;
    assign o_degen     = r_out_degen;
endmodule

FILE: sv/view_frustum_culling_unit.sv
// Top level of the view frustum culling unit: controller, datapath and channel glue.
// Depends on vfc_pkg, vfc_if, vfc_ctrl and vfc_dp.
//
// Works on one request at a time and answers every request with one response.
// Kinds 0/1 write one projection/modelview element. Kind 2 builds the clip matrix
// and the six normalized planes (right, left, bottom, top, back, front) in steps:
// 16 elements x (4 multiply/accumulate pairs + write), then per plane 4 sums, a
// zero check and, unless the normal is zero, 3 squares, a 32-step bit-serial square
// root, a 33-step restoring divide for the reciprocal and 4 scaling multiplies.
// A zero normal skips scaling and sets degenerate. Kinds 3/4/5 test a point, sphere
// or cube; each plane and corner tried takes a corner step, 4 multiply/accumulate
// pairs and a compare, stopping at the first plane that fails. All of this is
// paced by the one shared 32x32 multiplier and the serial root/divide unit. A
// finished response sits in an output register, so the next request is taken
// while it waits.
// All values are signed Q16.16; products round half away from zero and saturate.
module view_frustum_culling_unit import vfc_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    vfc_req_if.sink i_req,
    vfc_rsp_if.source o_rsp
);
    t_cmd  s_cmd;
    t_stat s_stat;
    t_req  s_req;

    // flatten the request channel for the datapath capture
    assign s_req.kind          = i_req.kind;
    assign s_req.element_index = i_req.element_index;
    assign s_req.element_value = i_req.element_value;
    assign s_req.pos_x         = i_req.pos_x;
    assign s_req.pos_y         = i_req.pos_y;
    assign s_req.pos_z         = i_req.pos_z;
    assign s_req.extent        = i_req.extent;

    vfc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_kind      (i_req.kind),
        .o_req_ready (i_req.ready),
        .o_cmd       (s_cmd),
        .i_stat      (s_stat),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_inside    (o_rsp.inside_res),
        .o_degen     (o_rsp.degenerate)
    );

    vfc_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (s_cmd),
        .i_req   (s_req),
        .o_stat  (s_stat)
    );

    // busy right after taking a request
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while previous one in progress");

    // a test result and a degenerate flag never come from the same request
    a_inside_not_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.inside_res) |-> !o_rsp.degenerate)
        else $error("inside and degenerate both set");

    // square root only runs on a nonzero normal
    a_sqrt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_cmd.op == OP_SQRT_STEP) |-> !s_stat.zero_normal)
        else $error("normalizing a zero normal");
endmodule

FILE: bench/view_frustum_culling_unit_tb.sv
// Self-checking bench for view_frustum_culling_unit: random and directed requests,
// predicted responses compared in order. Depends on vfc_pkg, vfc_if and the block.
`timescale 1ns / 1ps

module view_frustum_culling_unit_tb;
    import vfc_pkg::*;

    typedef struct {
        logic inside_res;
        logic degenerate;
    } t_answer;

    logic i_clk;
    logic i_rst_n;

    vfc_req_if req_if ();
    vfc_rsp_if rsp_if ();

    view_frustum_culling_unit uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    // Predictor state, held as wide signed values.
    longint proj_m[16];
    longint mv_m[16];
    longint planes[24];

    t_req    pending_q[$];
    t_answer answer_q[$];
    int      errors;
    // Driver pause until every outstanding response is back.
    bit      drain_req;

    localparam longint LMAX = 64'sd2147483647;
    localparam longint LMIN = -64'sd2147483648;

    function automatic longint clamp_w(longint v);
        return v > LMAX ? LMAX : (v < LMIN ? LMIN : v);
    endfunction

    // Rounded fixed-point product, half away from zero, saturated to the word.
    function automatic longint qmul(longint a, longint b);
        logic [127:0] p;
        logic [127:0] r;
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [63:0]  lim;
        bit           neg;
        neg = (a < 0) != (b < 0);
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        p = ma * mb;
        r = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        if (r > {64'd0, lim}) r = {64'd0, lim};
        return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
    endfunction

    function automatic longint plane_dist(int p, longint x, longint y, longint z);
        return qmul(planes[4*p], x) + qmul(planes[4*p+1], y)
             + qmul(planes[4*p+2], z) + planes[4*p+3];
    endfunction

    function automatic bit derive_planes();
        longint       clip[16];
        longint       s;
        logic [127:0] sq;
        logic [127:0] t;
        logic [63:0]  root;
        logic [63:0]  rcp;
        longint       v;
        bit           degen;
        int           c;
        degen = 0;
        for (int r = 0; r < 4; r++)
            for (int cc = 0; cc < 4; cc++) begin
                s = 0;
                for (int k = 0; k < 4; k++) s += qmul(mv_m[r*4+k], proj_m[k*4+cc]);
                clip[r*4+cc] = clamp_w(s);
            end
        for (int p = 0; p < 6; p++) begin
            c = p / 2;
            for (int r = 0; r < 4; r++) begin
                // right, top, back subtract the column; the others add it
                if (p == 0 || p == 3 || p == 4) v = clip[r*4+3] - clip[r*4+c];
                else v = clip[r*4+3] + clip[r*4+c];
                planes[4*p+r] = clamp_w(v);
            end
            if (planes[4*p] == 0 && planes[4*p+1] == 0 && planes[4*p+2] == 0) begin
                degen = 1;
            end else begin
                sq = 0;
                for (int r = 0; r < 3; r++) begin
                    t = (planes[4*p+r] < 0) ? -planes[4*p+r] : planes[4*p+r];
                    sq += t * t;
                end
                root = 0;
                for (int b = 49; b >= 0; b--) begin
                    t = {64'd0, root | (64'd1 << b)};
                    if (t * t <= sq) root = t[63:0];
                end
                if (root == 0) root = 1;
                rcp = ((64'd1 << (2 * FRAC_BITS)) + root / 2) / root;
                if (rcp > 64'd2147483647) rcp = 64'd2147483647;
                for (int r = 0; r < 4; r++) planes[4*p+r] = qmul(planes[4*p+r], rcp);
            end
        end
        return degen;
    endfunction

    function automatic t_answer predict_answer(t_req q);
        t_answer a;
        longint  x, y, z, e, cx, cy, cz;
        bit      all, ok;
        a.inside_res = 0;
        a.degenerate = 0;
        x = longint'(q.pos_x);
        y = longint'(q.pos_y);
        z = longint'(q.pos_z);
        e = longint'({1'b0, q.extent});
        case (q.kind)
            KIND_LD_PROJ: proj_m[q.element_index] = longint'(q.element_value);
            KIND_LD_MV:   mv_m[q.element_index] = longint'(q.element_value);
            KIND_COMPUTE: a.degenerate = derive_planes();
            KIND_POINT, KIND_SPHERE, KIND_CUBE: begin
                all = 1;
                for (int p = 0; p < 6 && all; p++) begin
                    ok = 0;
                    if (q.kind == KIND_POINT) ok = plane_dist(p, x, y, z) > 0;
                    else if (q.kind == KIND_SPHERE) ok = plane_dist(p, x, y, z) > -e;
                    else
                        for (int k = 0; k < 8 && !ok; k++) begin
                            cx = clamp_w(k[0] ? x + e : x - e);
                            cy = clamp_w(k[1] ? y + e : y - e);
                            cz = clamp_w(k[2] ? z + e : z - e);
                            ok = plane_dist(p, cx, cy, cz) > 0;
                        end
                    all = ok;
                end
                a.inside_res = all;
            end
            default: ;
        endcase
        return a;
    endfunction

    // Field helpers for the stimulus.
    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    function automatic t_req make_req(t_kind kd);
        t_req q;
        q.kind = kd;
        q.element_index = IDX_W'($urandom);
        q.element_value = $urandom;
        q.pos_x = $urandom;
        q.pos_y = $urandom;
        q.pos_z = $urandom;
        q.extent = EXT_W'($urandom);
        return q;
    endfunction

    function automatic t_req make_test(t_kind kd);
        t_req q;
        q = make_req(kd);
        if ($urandom_range(0, 3) != 0) begin
            q.pos_x = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            q.pos_y = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            q.pos_z = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            q.extent = EXT_W'($urandom_range(0, 32'h0004_0000));
        end
        return q;
    endfunction

    task automatic push_matrix(bit pretty);
        t_req q;
        for (int m = 0; m < 2; m++)
            for (int i = 0; i < 16; i++) begin
                q = make_req(m == 0 ? KIND_LD_PROJ : KIND_LD_MV);
                q.element_index = IDX_W'(i);
                if (pretty)
                    q.element_value = (i % 5 == 0) ? 32'h0001_0000
                        : $urandom_range(0, 32'h0000_8000) - 32'h0000_4000;
                else q.element_value = rnd_word();
                pending_q.push_back(q);
            end
        pending_q.push_back(make_req(KIND_COMPUTE));
    endtask

    // Clock and reset.
    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
    end

    // Driver: requests change on the falling edge.
    int  gap_left;
    int  rsp_gap;
    bit  drv_busy;
    initial begin
        req_if.valid = 0;
        req_if.kind = KIND_LD_PROJ;
        req_if.element_index = 0;
        req_if.element_value = 0;
        req_if.pos_x = 0;
        req_if.pos_y = 0;
        req_if.pos_z = 0;
        req_if.extent = 0;
        rsp_if.ready = 0;
        gap_left = 0;
        rsp_gap = 0;
        drv_busy = 0;
    end

    bit req_fire;
    bit rsp_fire;
    always @(posedge i_clk) begin
        req_fire <= i_rst_n && req_if.valid && req_if.ready;
        rsp_fire <= i_rst_n && rsp_if.valid && rsp_if.ready;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 0;
        end else begin
            if (req_fire) drv_busy = 0;
            if (!drv_busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_if.valid <= 0;
                end else if (pending_q.size() != 0 && pending_q[0].kind == 3'd7
                             && drain_req) begin
                    // marker item: hold off until the response queue empties
                    req_if.valid <= 0;
                    if (answer_q.size() == 0) void'(pending_q.pop_front());
                end else if (pending_q.size() != 0) begin
                    t_req q;
                    q = pending_q.pop_front();
                    answer_q.push_back(predict_answer(q));
                    req_if.kind <= q.kind;
                    req_if.element_index <= q.element_index;
                    req_if.element_value <= q.element_value;
                    req_if.pos_x <= q.pos_x;
                    req_if.pos_y <= q.pos_y;
                    req_if.pos_z <= q.pos_z;
                    req_if.extent <= q.extent;
                    req_if.valid <= 1;
                    drv_busy = 1;
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
                end else begin
                    req_if.valid <= 0;
                end
            end
            // Receiver stalls: a fresh wait is drawn after each response.
            if (rsp_fire) rsp_gap = $urandom_range(0, 9);
            rsp_if.ready <= (rsp_gap == 0);
            if (rsp_if.valid && rsp_gap > 0) rsp_gap--;
        end
    end

    // Monitor: responses sampled at the rising edge.
    always @(posedge i_clk) begin
        t_answer a;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (answer_q.size() == 0) begin
                $display("%0t: response with nothing expected: inside %b degenerate %b",
                         $realtime, rsp_if.inside_res, rsp_if.degenerate);
                errors++;
            end else begin
                a = answer_q.pop_front();
                if (a.inside_res !== rsp_if.inside_res) begin
                    $display("%0t: inside_res expected %b actual %b", $realtime,
                             a.inside_res, rsp_if.inside_res);
                    errors++;
                end
                if (a.degenerate !== rsp_if.degenerate) begin
                    $display("%0t: degenerate expected %b actual %b", $realtime,
                             a.degenerate, rsp_if.degenerate);
                    errors++;
                end
            end
        end
    end

    // Stimulus.
    initial begin
        t_req q;
        int   n;
        errors = 0;
        drain_req = 1;
        // Directed: tests before any compute, an unused kind, zero-matrix compute, then extreme values.
        pending_q.push_back(make_test(KIND_POINT));
        pending_q.push_back(make_test(KIND_SPHERE));
        pending_q.push_back(make_test(KIND_CUBE));
        pending_q.push_back(make_req(3'd6));
        pending_q.push_back(make_req(KIND_COMPUTE));
        q = make_req(KIND_LD_PROJ);
        q.element_index = 4'd15;
        q.element_value = 32'h7fffffff;
        pending_q.push_back(q);
        q.kind = KIND_LD_MV;
        q.element_index = 4'd0;
        q.element_value = 32'h80000000;
        pending_q.push_back(q);
        pending_q.push_back(make_req(KIND_COMPUTE));
        q = make_req(KIND_CUBE);
        q.pos_x = 32'h7fffffff;
        q.pos_y = 32'h80000000;
        q.pos_z = 0;
        q.extent = 31'h7fffffff;
        pending_q.push_back(q);
        q.kind = KIND_SPHERE;
        pending_q.push_back(q);
        q.kind = KIND_POINT;
        q.pos_x = 0;
        q.pos_y = 32'hffffffff;
        pending_q.push_back(q);
        // pause until drained
        pending_q.push_back(make_req(3'd7));
        // Random: mostly sensible matrices followed by tests, some noise.
        n = 0;
        while (n < 950) begin
            push_matrix($urandom_range(0, 3) != 0);
            n += 33;
            for (int i = 0; i < 12; i++) begin
                case ($urandom_range(0, 19))
                    0: q = make_req(t_kind'(3'd6 + $urandom_range(0, 1)));
                    1: q = make_req(t_kind'($urandom_range(0, 1)));
                    default: q = make_test(t_kind'(KIND_POINT + $urandom_range(0, 2)));
                endcase
                if (q.kind == 3'd7) q.kind = 3'd6;
                pending_q.push_back(q);
                n++;
            end
        end
        wait (pending_q.size() == 0 && !drv_busy && !req_if.valid);
        wait (answer_q.size() == 0);
        repeat (700) @(posedge i_clk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end
endmodule
